[sv/largest_free_square_scan_macros.svh]
// Assertion macros for the largest free square scan checker.
// Depends on signals named aclk and aresetn in the module that uses them.
`ifndef LARGEST_FREE_SQUARE_SCAN_MACROS_SVH
`define LARGEST_FREE_SQUARE_SCAN_MACROS_SVH

// Concurrent assertion clocked on aclk and switched off while reset is held.
`define LFSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication form of the above: the consequent is checked in the cycle after the antecedent.
`define LFSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lfss_pkg.sv]
// Package of the largest free square scan: sizes, map characters and item types.
// Depends on nothing; used by the top level and its checker.
package lfss_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 4096;

    localparam int SIZE_W = $clog2(MAX_COLS) + 1;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);

    localparam logic [7:0] CHAR_FREE     = 8'h2E;
    localparam logic [7:0] CHAR_OBSTACLE = 8'h6F;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic       last_cell;
    } lfss_in_t;

    typedef struct packed {
        size_t square_size;
        size_t best_size;
        row_t  best_row;
        col_t  best_col;
        logic  invalid_char;
        logic  map_end;
    } lfss_out_t;

endpackage

[sv/largest_free_square_scan.sv]
// Top level of the largest free square scan over a streamed character map.
// Depends on lfss_pkg; holds the previous-row line store as an inferred memory.
//
// Usage: map cells enter on the s_ channel in row-major order, one character
// per item, with last_cell marking the final cell of a map. Each accepted item
// yields exactly one result item on the m_ channel: the square side ending at
// that cell, the best side so far with its bottom-right corner, an error flag
// for characters other than free or obstacle, and the end-of-map mark.
// The user must write the row length register through cfg_wr_en and cfg_wr_data
// only while no item is in flight, which the block does not enforce; a write
// takes effect for the next item. Throughput is one item per cycle while the
// receiver takes results: the line store is read one cell ahead, at the column
// the next item will use, and a same-column write is forwarded.
// Reset clears the position, the running best and the output valid flag and
// sets the row length to 1024; the line store keeps its contents, since the
// first row never reads it. When the receiver stalls, the result is held and
// s_ready falls, so at most one result waits in the output register.
module largest_free_square_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lfss_pkg::lfss_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output lfss_pkg::lfss_out_t m_item,
    input  logic                cfg_wr_en,
    input  lfss_pkg::size_t     cfg_wr_data
);
    import lfss_pkg::*;

    localparam size_t MAX_LEN = size_t'(MAX_COLS);
    localparam row_t  LAST_ROW = row_t'(MAX_ROWS - 1);

    size_t     row_length_reg;
    size_t     left_size_reg, left_size_next;
    size_t     diag_size_reg, diag_size_next;
    row_t      row_index_reg, row_index_next;
    col_t      col_index_reg, col_index_next;
    size_t     best_size_reg, best_size_next;
    row_t      best_row_reg, best_row_next;
    col_t      best_col_reg, best_col_next;
    size_t     line_q_reg;
    logic      byp_valid_reg, byp_valid_next;
    size_t     byp_data_reg;
    logic      m_valid_reg;
    lfss_out_t m_item_reg, m_item_next;

    size_t line_mem [MAX_COLS];

    logic  in_accept;
    size_t eff_len;
    logic  first_row, first_col, row_end, is_free, is_obstacle;
    size_t up_size, left_size, diag_size, min_lu, min_all, square_size;
    col_t  rd_addr;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_comb begin
        if (row_length_reg == '0) begin
            eff_len = size_t'(1);
        end else if (row_length_reg > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = row_length_reg;
        end
    end

    always_comb begin
        first_row   = (row_index_reg == '0);
        first_col   = (col_index_reg == '0);
        row_end     = (size_t'(col_index_reg) + size_t'(1)) >= eff_len;
        is_free     = (s_item.cell_char == CHAR_FREE);
        is_obstacle = (s_item.cell_char == CHAR_OBSTACLE);

        up_size   = first_row ? '0 : (byp_valid_reg ? byp_data_reg : line_q_reg);
        left_size = first_col ? '0 : left_size_reg;
        diag_size = (first_row || first_col) ? '0 : diag_size_reg;

        min_lu      = (up_size < left_size) ? up_size : left_size;
        min_all     = (diag_size < min_lu) ? diag_size : min_lu;
        square_size = is_free ? min_all + size_t'(1) : '0;

        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (square_size > best_size_reg) begin
            best_size_next = square_size;
            best_row_next  = row_index_reg;
            best_col_next  = col_index_reg;
        end

        m_item_next.square_size  = square_size;
        m_item_next.best_size    = best_size_next;
        m_item_next.best_row     = best_row_next;
        m_item_next.best_col     = best_col_next;
        m_item_next.invalid_char = !is_free && !is_obstacle;
        m_item_next.map_end      = s_item.last_cell;

        left_size_next = square_size;
        diag_size_next = up_size;
        row_index_next = row_index_reg;
        col_index_next = col_index_reg + col_t'(1);
        if (row_end) begin
            left_size_next = '0;
            diag_size_next = '0;
            col_index_next = '0;
            if (row_index_reg != LAST_ROW) begin
                row_index_next = row_index_reg + row_t'(1);
            end
        end
        if (s_item.last_cell) begin
            left_size_next = '0;
            diag_size_next = '0;
            row_index_next = '0;
            col_index_next = '0;
            best_size_next = '0;
            best_row_next  = '0;
            best_col_next  = '0;
        end

        rd_addr        = in_accept ? col_index_next : col_index_reg;
        byp_valid_next = in_accept && (col_index_next == col_index_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= MAX_LEN;
            left_size_reg  <= '0;
            diag_size_reg  <= '0;
            row_index_reg  <= '0;
            col_index_reg  <= '0;
            best_size_reg  <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            byp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                row_length_reg <= cfg_wr_data;
            end
            byp_valid_reg <= byp_valid_next;
            if (in_accept) begin
                left_size_reg <= left_size_next;
                diag_size_reg <= diag_size_next;
                row_index_reg <= row_index_next;
                col_index_reg <= col_index_next;
                best_size_reg <= best_size_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_item_reg   <= m_item_next;
            byp_data_reg <= square_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            line_mem[col_index_reg] <= square_size;
        end
        line_q_reg <= line_mem[rd_addr];
    end

endmodule

[sv/lfss_checker.sv]
// Port-level checker for the largest free square scan, bound to the top level.
// Depends on lfss_pkg and largest_free_square_scan_macros.svh.
`include "largest_free_square_scan_macros.svh"

module lfss_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lfss_pkg::lfss_out_t m_item
);
    import lfss_pkg::*;

    `LFSS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_item), "Stalled result item changed.")
    `LFSS_ASSERT_NEXT(a_result_follows, s_valid && s_ready, m_valid, "Accepted item gave no result item.")
    `LFSS_ASSERT(a_best_covers, m_valid |-> (m_item.best_size >= m_item.square_size), "Best size below cell size.")
    `LFSS_ASSERT(a_invalid_blocked, (m_valid && m_item.invalid_char) |-> (m_item.square_size == '0), "Invalid character gave a square.")

endmodule

bind largest_free_square_scan lfss_checker u_lfss_checker (.*);

[verif/largest_free_square_scan_tb.sv]
// Self-checking testbench for largest_free_square_scan: streams character maps through the
// block under random flow control and checks every result against predicted or directed values.
// Depends on lfss_pkg and the largest_free_square_scan RTL only.
module largest_free_square_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfss_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_CELLS = 800;

    typedef enum logic [1:0] {STEP_CELL, STEP_KNOWN, STEP_ROW_LEN} step_op_e;

    typedef struct {
        step_op_e  op;
        lfss_in_t  item;
        size_t     len;
        lfss_out_t want;
    } map_step_t;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    lfss_in_t  s_item      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    lfss_out_t m_item;
    logic      cfg_wr_en   = 1'b0;
    size_t     cfg_wr_data = '0;

    int gap_pct   = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int mismatches  = 0;
    int cells_sent  = 0;

    lfss_out_t pending_squares[$];

    size_t line_sizes [MAX_COLS];
    bit    line_written [MAX_COLS];
    size_t left_sz, diag_sz, best_sz, row_len_reg;
    row_t  cur_row, best_r;
    col_t  cur_col, best_c;

    largest_free_square_scan dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int active_length(input size_t v);
        if (v == 0) return 1;
        if (v > MAX_COLS) return MAX_COLS;
        return int'(v);
    endfunction

    function automatic void clear_scan();
        left_sz = '0;
        diag_sz = '0;
        cur_row = '0;
        cur_col = '0;
        best_sz = '0;
        best_r  = '0;
        best_c  = '0;
    endfunction

    function automatic lfss_out_t scan_next_cell(input lfss_in_t c);
        lfss_out_t r;
        size_t     up, lft, dg, m, sz;
        up  = (cur_row == 0) ? '0 : line_sizes[cur_col];
        lft = (cur_col == 0) ? '0 : left_sz;
        dg  = (cur_row == 0 || cur_col == 0) ? '0 : diag_sz;
        sz  = '0;
        if (c.cell_char == CHAR_FREE) begin
            m = lft;
            if (up < m) m = up;
            if (dg < m) m = dg;
            sz = m + 1'b1;
        end
        if (sz > best_sz) begin
            best_sz = sz;
            best_r  = cur_row;
            best_c  = cur_col;
        end
        diag_sz = up;
        line_sizes[cur_col]   = sz;
        line_written[cur_col] = 1'b1;
        left_sz = sz;
        r.square_size  = sz;
        r.best_size    = best_sz;
        r.best_row     = best_r;
        r.best_col     = best_c;
        r.invalid_char = (c.cell_char != CHAR_FREE) && (c.cell_char != CHAR_OBSTACLE);
        r.map_end      = c.last_cell;
        if (int'(cur_col) + 1 >= active_length(row_len_reg)) begin
            cur_col = '0;
            left_sz = '0;
            diag_sz = '0;
            if (int'(cur_row) + 1 < MAX_ROWS) cur_row = cur_row + 1'b1;
        end else begin
            cur_col = cur_col + 1'b1;
        end
        if (c.last_cell) clear_scan();
        return r;
    endfunction

    // A longer row part-way through a map must not reach line-store entries never written.
    function automatic bit length_is_safe(input size_t v);
        if (cur_row == 0) return 1'b1;
        for (int i = 0; i < active_length(v); i++) begin
            if (!line_written[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic size_t pick_row_length();
        size_t v;
        case ($urandom_range(9))
            0: v = size_t'($urandom_range(2047, MAX_COLS + 1));
            1: v = '0;
            default: v = size_t'($urandom_range(12, 1));
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_char(input int free_pct, input int bad_pct);
        int r;
        r = $urandom_range(99);
        if (r < bad_pct) return 8'($urandom_range(255));
        if (r < bad_pct + free_pct) return CHAR_FREE;
        return CHAR_OBSTACLE;
    endfunction

    function automatic map_step_t step_cell(input logic [7:0] ch, input logic fin);
        map_step_t s;
        s.op             = STEP_CELL;
        s.item.cell_char = ch;
        s.item.last_cell = fin;
        s.len            = '0;
        s.want           = '0;
        return s;
    endfunction

    function automatic map_step_t step_known(input logic [7:0] ch, input logic fin,
                                             input int sq, input int best, input int r,
                                             input int c, input logic bad);
        map_step_t s;
        s = step_cell(ch, fin);
        s.op                = STEP_KNOWN;
        s.want.square_size  = size_t'(sq);
        s.want.best_size    = size_t'(best);
        s.want.best_row     = row_t'(r);
        s.want.best_col     = col_t'(c);
        s.want.invalid_char = bad;
        s.want.map_end      = fin;
        return s;
    endfunction

    function automatic map_step_t step_len(input int v);
        map_step_t s;
        s = step_cell(CHAR_OBSTACLE, 1'b0);
        s.op  = STEP_ROW_LEN;
        s.len = size_t'(v);
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [11:0] want,
                                        input logic [11:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_cell(input lfss_in_t c, input bit known, input lfss_out_t want);
        lfss_out_t predicted;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= c;
        do @(posedge aclk); while (!s_ready);
        predicted = scan_next_cell(c);
        pending_squares.push_back(known ? want : predicted);
        cells_sent++;
    endtask

    task automatic set_row_length(input size_t v);
        s_valid <= 1'b0;
        while (pending_squares.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        row_len_reg = v;
    endtask

    task automatic scan_map(input int n_cells, input int free_pct, input int bad_pct);
        lfss_in_t c;
        int       retune_at;
        size_t    v;
        retune_at = ($urandom_range(5) == 0) ? int'($urandom_range(n_cells - 1)) : -1;
        for (int i = 0; i < n_cells; i++) begin
            if (i == retune_at) begin
                v = pick_row_length();
                set_row_length(length_is_safe(v) ? v : size_t'(1));
            end
            c.cell_char = pick_char(free_pct, bad_pct);
            c.last_cell = (i == n_cells - 1);
            send_cell(c, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        lfss_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_squares.size() == 0) begin
                mismatches++;
                $display("%0t ns: result %p arrived with none expected", $time, m_item);
            end else begin
                want = pending_squares.pop_front();
                check_field("square_size", 12'(want.square_size), 12'(m_item.square_size));
                check_field("best_size", 12'(want.best_size), 12'(m_item.best_size));
                check_field("best_row", want.best_row, m_item.best_row);
                check_field("best_col", 12'(want.best_col), 12'(m_item.best_col));
                check_field("invalid_char", 12'(want.invalid_char),
                            12'(m_item.invalid_char));
                check_field("map_end", 12'(want.map_end), 12'(m_item.map_end));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid === 1'b1 && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        map_step_t directed[$];
        int        base;

        row_len_reg = size_t'(MAX_COLS);
        clear_scan();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed = '{
            step_known(CHAR_FREE,     1'b0, 1, 1, 0, 0, 1'b0),
            step_known(CHAR_OBSTACLE, 1'b0, 0, 1, 0, 0, 1'b0),
            step_known(8'h00,         1'b0, 0, 1, 0, 0, 1'b1),
            step_known(8'hFF,         1'b1, 0, 1, 0, 0, 1'b1),
            step_known(CHAR_OBSTACLE, 1'b1, 0, 0, 0, 0, 1'b0),
            step_len(3),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_known(CHAR_FREE,     1'b1, 3, 3, 2, 2, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(8'h2F,     1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_cell(CHAR_FREE, 1'b0),
            step_len(1),
            step_cell(CHAR_FREE, 1'b0),
            step_len(0),
            step_cell(CHAR_FREE, 1'b0),
            step_known(8'h6E,         1'b1, 0, 1, 0, 0, 1'b1)
        };

        foreach (directed[i]) begin
            case (directed[i].op)
                STEP_ROW_LEN: set_row_length(directed[i].len);
                STEP_KNOWN:   send_cell(directed[i].item, 1'b1, directed[i].want);
                default:      send_cell(directed[i].item, 1'b0, '0);
            endcase
        end

        base = cells_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
                1: begin gap_pct = 73; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 73; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            while (cells_sent - base < (phase + 1) * (RANDOM_CELLS / 4)) begin
                if ($urandom_range(2) != 0) set_row_length(pick_row_length());
                scan_map(($urandom_range(8) == 0) ? $urandom_range(150, 60)
                                                  : $urandom_range(40, 1),
                         $urandom_range(95, 50),
                         ($urandom_range(7) == 0) ? 40 : $urandom_range(3));
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        set_row_length(size_t'(MAX_COLS));
        scan_map(40, 80, 2);

        s_valid <= 1'b0;
        while (pending_squares.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[largest_free_square_scan.f]
+incdir+sv
sv/lfss_pkg.sv
sv/largest_free_square_scan.sv
sv/lfss_checker.sv
verif/largest_free_square_scan_tb.sv
